// ===== rtl/rws_pkg.sv =====
`default_nettype none

package rws_pkg;

    localparam int MAX_POP  = 256;
    localparam int FIT_W    = 32;
    localparam int RND_W    = 32;
    localparam int IDX_W    = $clog2(MAX_POP);
    localparam int CNT_W    = $clog2(MAX_POP + 1);
    localparam int TOT_W    = FIT_W + $clog2(MAX_POP);
    localparam int CHOSEN_W = 8;
    localparam int STATUS_W = 2;
    localparam int SIZE_W   = 9;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_LOADED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_TOTAL = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PICK = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/rws_ram.sv =====
`default_nettype none

module rws_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== rtl/rws_mod.sv =====
`default_nettype none

// Restoring remainder, one dividend bit per cycle.
module rws_mod (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [rws_pkg::RND_W-1:0]  dividend,
    input  wire logic [rws_pkg::TOT_W-1:0]  divisor,
    output logic                            done,
    output logic      [rws_pkg::RND_W-1:0]  remainder
);
    import rws_pkg::*;

    localparam int STEP_W = $clog2(RND_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [RND_W-1:0]    dvd_reg, dvd_next;
    logic [TOT_W-1:0]    dsr_reg, dsr_next;
    logic [TOT_W-1:0]    rem_reg, rem_next;
    logic [TOT_W:0]      shifted;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        shifted   = {rem_reg, dvd_reg[RND_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(RND_W - 1);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dsr_reg})
            begin
                rem_next = TOT_W'(shifted - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = shifted[TOT_W-1:0];
            end
            dvd_next  = {dvd_reg[RND_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    // remainder never exceeds the dividend
    assign remainder = rem_reg[RND_W-1:0];
    assign done      = done_reg;

`ifndef NO_ASSERTIONS
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> rem_reg < dsr_reg)
        else $error("remainder not below divisor");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("done without a running division");
`endif

endmodule

`default_nettype wire

// ===== rtl/roulette_wheel_selector_top.sv =====
// Load item: the store entry and the running total are updated at the accepting edge.
// Pick item: an error status passes through the S_OUT state to the output register; a valid
// pick first runs the serial remainder, then walks the store entries in order (up to 256),
// limited by the remainder unit and the single store read port.
// One item is in work at a time; the output register lets the next item in early.
// Reset clears count, total and control, sets pop_size to 256; the store is not cleared.
`default_nettype none

module roulette_wheel_selector_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [63:0]                  s_tdata,   // fitness_value, random_value
    input  wire logic [1:0]                   s_tuser,   // cmd, first
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [7:0]                   m_tdata,   // chosen_index
    output logic      [1:0]                   m_tuser,   // status
    input  wire logic                         cfg_wen,
    input  wire logic [rws_pkg::SIZE_W-1:0]   cfg_wdata
);
    import rws_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MOD  = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [SIZE_W-1:0]    pop_size_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [TOT_W-1:0]     total_reg, total_next;
    logic [RND_W-1:0]     pick_reg, pick_next;
    logic [TOT_W-1:0]     running_reg, running_next;
    logic [IDX_W-1:0]     walk_idx_reg, walk_idx_next;
    logic [IDX_W-1:0]     res_idx_reg, res_idx_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                 m_valid_reg, m_valid_next;
    logic [CHOSEN_W-1:0]  m_idx_reg, m_idx_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;

    logic [CNT_W-1:0]     eff_size;
    logic                 accept;
    logic                 in_cmd, in_first;
    logic [FIT_W-1:0]     in_fit;
    logic [RND_W-1:0]     in_rnd;
    logic [CNT_W-1:0]     wr_slot;
    logic                 wr_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [FIT_W-1:0]     rd_data;
    logic [TOT_W-1:0]     sum;
    logic                 mod_start, mod_done;
    logic [RND_W-1:0]     mod_rem;
    logic                 out_free;

    assign in_cmd   = s_tuser[0];
    assign in_first = s_tuser[1];
    assign in_fit   = s_tdata[FIT_W-1:0];
    assign in_rnd   = s_tdata[FIT_W +: RND_W];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        priority if (pop_size_reg == '0)
        begin
            eff_size = CNT_W'(1);
        end
        else if (pop_size_reg > SIZE_W'(MAX_POP))
        begin
            eff_size = CNT_W'(MAX_POP);
        end
        else
        begin
            eff_size = CNT_W'(pop_size_reg);
        end
    end

    assign wr_slot = in_first ? '0 : count_reg;
    assign wr_en   = accept && (in_cmd == CMD_LOAD) && (in_first || count_reg < eff_size);
    assign sum     = running_reg + TOT_W'(rd_data);
    assign rd_addr = (state_reg == S_WALK) ? walk_idx_reg + 1'b1 : '0;

    rws_ram #(
        .DEPTH (MAX_POP),
        .WIDTH (FIT_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_slot[IDX_W-1:0]),
        .wr_data (in_fit),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rws_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (in_rnd),
        .divisor   (total_reg),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        pick_next       = pick_reg;
        running_next    = running_reg;
        walk_idx_next   = walk_idx_reg;
        res_idx_next    = res_idx_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_idx_next      = m_idx_reg;
        m_status_next   = m_status_reg;
        mod_start       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_cmd == CMD_LOAD)
                    begin
                        if (wr_en)
                        begin
                            count_next = wr_slot + 1'b1;
                            total_next = (in_first ? '0 : total_reg) + TOT_W'(in_fit);
                        end
                    end
                    else if (count_reg != eff_size)
                    begin
                        res_idx_next    = '0;
                        res_status_next = ST_NOT_LOADED;
                        state_next      = S_OUT;
                    end
                    else if (total_reg == '0)
                    begin
                        res_idx_next    = '0;
                        res_status_next = ST_ZERO_TOTAL;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_MOD;
                    end
                end
            end
            S_MOD:
            begin
                // read of entry zero goes out this cycle
                if (mod_done)
                begin
                    pick_next     = mod_rem;
                    running_next  = '0;
                    walk_idx_next = '0;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                if (sum > TOT_W'(pick_reg) || CNT_W'(walk_idx_reg) == count_reg - 1'b1)
                begin
                    res_idx_next    = walk_idx_reg;
                    res_status_next = ST_OK;
                    state_next      = S_OUT;
                end
                else
                begin
                    running_next  = sum;
                    walk_idx_next = walk_idx_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_idx_next    = CHOSEN_W'(res_idx_reg);
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            pop_size_reg <= SIZE_W'(256);
            count_reg    <= '0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wen)
            begin
                pop_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg       <= pick_next;
        running_reg    <= running_next;
        walk_idx_reg   <= walk_idx_next;
        res_idx_reg    <= res_idx_next;
        res_status_reg <= res_status_next;
        m_idx_reg      <= m_idx_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_idx_reg;
    assign m_tuser  = m_status_reg;

`ifndef NO_ASSERTIONS
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POP))
        else $error("loaded count above capacity");

    a_walk_needs_full_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (count_reg == eff_size && total_reg != '0))
        else $error("walk started without a full nonzero population");

    a_walk_below_pick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> running_reg <= TOT_W'(pick_reg))
        else $error("running sum passed the pick without a result");

    a_pick_below_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> TOT_W'(pick_reg) < total_reg)
        else $error("reduced pick not below total");

    a_done_in_mod: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> state_reg == S_MOD)
        else $error("remainder finished outside its state");
`endif

endmodule

`default_nettype wire

// ===== bench/rws_result_checker.sv =====
`timescale 1ns / 100ps

module rws_result_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    input  wire logic                         s_tready,
    input  wire logic [63:0]                  s_tdata,   // fitness_value, random_value
    input  wire logic [1:0]                   s_tuser,   // cmd, first
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [7:0]                   m_tdata,   // chosen_index
    input  wire logic [1:0]                   m_tuser,   // status
    input  wire logic                         cfg_wen,
    input  wire logic [rws_pkg::SIZE_W-1:0]   cfg_wdata,
    output int                                mismatches,
    output int                                outstanding,
    output int                                results_seen
);
    import rws_pkg::*;

    typedef struct packed {
        logic [CHOSEN_W-1:0] chosen;
        logic [STATUS_W-1:0] status;
    } pick_result_t;

    bit [FIT_W-1:0]  wheel_fit [MAX_POP];
    int unsigned     wheel_count;
    bit [TOT_W-1:0]  wheel_total;
    bit [SIZE_W-1:0] pop_size_reg;
    pick_result_t    picks_due_q[$];

    function automatic int unsigned live_size();
        int unsigned s;
        s = pop_size_reg;
        if (s == 0)
            s = 1;
        if (s > MAX_POP)
            s = MAX_POP;
        return s;
    endfunction

    function automatic void add_fitness(input logic first, input logic [FIT_W-1:0] fit);
        if (first)
        begin
            wheel_count = 0;
            wheel_total = '0;
        end
        // a full population drops further values
        if (wheel_count < live_size())
        begin
            wheel_fit[wheel_count] = fit;
            wheel_total += TOT_W'(fit);
            wheel_count++;
        end
    endfunction

    function automatic pick_result_t spin_wheel(input logic [RND_W-1:0] rnd);
        pick_result_t r;
        bit [63:0]    target;
        bit [63:0]    running;
        int unsigned  i;
        r.chosen = '0;
        r.status = ST_OK;
        if (wheel_count != live_size())
            r.status = ST_NOT_LOADED;
        else if (wheel_total == '0)
            r.status = ST_ZERO_TOTAL;
        else
        begin
            target  = 64'(rnd) % 64'(wheel_total);
            running = '0;
            for (i = 0; i < wheel_count; i++)
            begin
                running += 64'(wheel_fit[i]);
                if (running > target)
                begin
                    r.chosen = CHOSEN_W'(i);
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ERROR %s", $realtime, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pick_result_t want;
        if (!rst_n)
        begin
            wheel_count  = 0;
            wheel_total  = '0;
            pop_size_reg = SIZE_W'(MAX_POP);
            picks_due_q.delete();
            mismatches   = 0;
            results_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wen)
                pop_size_reg = cfg_wdata;

            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (picks_due_q.size() == 0)
                    report_mismatch($sformatf("result %0d with no pick pending: index %0d status %0d",
                                              results_seen, m_tdata, m_tuser));
                else
                begin
                    want = picks_due_q.pop_front();
                    if (m_tdata !== want.chosen)
                        report_mismatch($sformatf("result %0d chosen_index %0d, want %0d",
                                                  results_seen, m_tdata, want.chosen));
                    if (m_tuser !== want.status)
                        report_mismatch($sformatf("result %0d status %0d, want %0d",
                                                  results_seen, m_tuser, want.status));
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (s_tuser[0] == CMD_LOAD)
                    add_fitness(s_tuser[1], s_tdata[31:0]);
                else
                    picks_due_q.push_back(spin_wheel(s_tdata[63:32]));
            end

            outstanding <= picks_due_q.size();
        end
    end

endmodule

// ===== bench/roulette_wheel_selector_top_test.sv =====
`timescale 1ns / 100ps

module roulette_wheel_selector_top_test;

    import rws_pkg::*;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [63:0]         s_tdata   = '0;
    logic [1:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;
    logic [1:0]          m_tuser;
    logic                cfg_wen   = 1'b0;
    logic [SIZE_W-1:0]   cfg_wdata = '0;

    int mismatches;
    int outstanding;
    int results_seen;

    int loads_sent;
    int picks_sent;
    int cfg_writes;
    bit steady;
    int hold_asks;
    int hold_taken;
    int hold_left;

    roulette_wheel_selector_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    rws_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_wen      (cfg_wen),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    always #5 clk = ~clk;

    // result side: random stalls, plus a long hold whenever the stimulus asks for one
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_taken)
        begin
            hold_taken <= hold_asks;
            hold_left  <= 1500;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= steady || ($urandom_range(99) >= 30);
    end

    initial
    begin
        #40_000_000;
        $display("timeout with %0d picks still pending", outstanding);
        $display("FAILED: results differ");
        $finish;
    end

    task automatic send_item(input logic cmd, input logic first,
                             input logic [31:0] fit, input logic [31:0] rnd);
        while (!steady && $urandom_range(99) < 30)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {rnd, fit};
        s_tuser  <= {first, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd == CMD_PICK)
            picks_sent++;
        else
            loads_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // loads leave no result behind; wait further so the block can settle
        repeat (8) @(posedge clk);
    endtask

    task automatic set_pop(input logic [SIZE_W-1:0] value);
        wait_drained();
        cfg_wen   <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        cfg_writes++;
    endtask

    function automatic int unsigned live_count(input int unsigned p);
        if (p == 0)
            return 1;
        return (p > MAX_POP) ? MAX_POP : p;
    endfunction

    function automatic logic [31:0] next_fitness(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(15);
            2: return ($urandom_range(3) == 0) ? $urandom_range(1000) : 32'd0;
            3: return 32'd0;
            default: return 32'hFFFF_FFFF - $urandom_range(255);
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0: return $urandom_range(31);
            1: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        int          phase;
        int unsigned p;
        int unsigned n;
        int unsigned nload;
        int          mode;
        int          kind;
        int          r;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default size with nothing loaded, then single-member wheel
        send_item(CMD_PICK, 1'b0, $urandom(), 32'd0);
        set_pop(9'd1);
        send_item(CMD_PICK, 1'b1, $urandom(), $urandom());
        send_item(CMD_LOAD, 1'b1, 32'd0, $urandom());
        send_item(CMD_PICK, 1'b0, $urandom(), $urandom());
        send_item(CMD_LOAD, 1'b0, 32'd5, $urandom());
        send_item(CMD_PICK, 1'b1, $urandom(), 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 1'b1, 32'hFFFF_FFFF, $urandom());
        send_item(CMD_PICK, 1'b0, $urandom(), 32'hFFFF_FFFF);
        // size zero acts as one member
        set_pop(9'd0);
        send_item(CMD_PICK, 1'b0, $urandom(), $urandom());
        // size changed after loading, then a zero entry and the pick boundaries
        set_pop(9'd3);
        send_item(CMD_PICK, 1'b0, $urandom(), $urandom());
        send_item(CMD_LOAD, 1'b1, 32'd0, $urandom());
        send_item(CMD_LOAD, 1'b0, 32'hFFFF_FFFF, $urandom());
        send_item(CMD_LOAD, 1'b0, 32'd1, $urandom());
        send_item(CMD_PICK, 1'b1, 32'hFFFF_FFFF, 32'd0);
        send_item(CMD_PICK, 1'b0, 32'd0, 32'hFFFF_FFFE);
        send_item(CMD_PICK, 1'b1, $urandom(), 32'hFFFF_FFFF);
        send_item(CMD_LOAD, 1'b0, 32'd9, $urandom());
        send_item(CMD_PICK, 1'b0, $urandom(), $urandom());
        send_item(CMD_LOAD, 1'b1, 32'd7, $urandom());
        send_item(CMD_PICK, 1'b0, $urandom(), $urandom());

        phase = 0;
        while (loads_sent + picks_sent < 1750)
        begin
            phase++;
            steady = (phase >= 8 && phase <= 12);
            r = $urandom_range(99);
            if (phase == 1)
                p = 511;
            else if (phase == 2)
                p = 256;
            else if (r < 60)
                p = $urandom_range(1, 12);
            else if (r < 85)
                p = $urandom_range(13, 64);
            else if (r < 95)
                p = $urandom_range(65, 255);
            else if (r < 98)
                p = 0;
            else
                p = $urandom_range(257, 511);
            set_pop(SIZE_W'(p));
            n    = live_count(p);
            mode = (phase == 1) ? 4 : $urandom_range(4);
            kind = (phase <= 2) ? 9 : $urandom_range(9);

            // restart a few times before the real fill
            if (kind == 0)
                repeat ($urandom_range(1, 3))
                    send_item(CMD_LOAD, 1'b1, $urandom(), $urandom());
            nload = (kind == 1 && n > 1) ? $urandom_range(1, n - 1) : n;
            for (int unsigned i = 0; i < nload; i++)
                send_item(CMD_LOAD, i == 0, next_fitness(mode), $urandom());
            // drop extra loads into a full wheel
            if (kind == 2)
                repeat ($urandom_range(1, 3))
                    send_item(CMD_LOAD, 1'b0, $urandom(), $urandom());
            if (kind == 3)
                set_pop(SIZE_W'($urandom_range(511)));

            if (phase == 1)
            begin
                // hold off the result side so the block backs up into its input
                hold_asks++;
                repeat (8)
                    send_item(CMD_PICK, 1'($urandom_range(1)), $urandom(), pick_word());
                wait_drained();
            end
            repeat ($urandom_range(2, 10))
                send_item(CMD_PICK, 1'($urandom_range(1)), $urandom(), pick_word());
        end
        steady = 1'b0;

        wait_drained();
        repeat (300) @(posedge clk);

        $display("Run covered %0d loads and %0d picks over %0d phases, %0d pop_size writes.",
                 loads_sent, picks_sent, phase, cfg_writes);
        $display("Checked %0d results, %0d mismatches.", results_seen, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
